[hdl/dvrt_pkg.sv]
// ============================================================================
// dvrt_pkg
// Shared types and constants of the distance-vector route table.
// ============================================================================
`default_nettype none

package dvrt_pkg;

    localparam int ROUTERS_DEF   = 16;
    localparam int DIST_BITS_DEF = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index (byte address / 4)
    localparam logic [APB_ADDR_W-3:0] REG_SELF_ID = '0;

    // command codes
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_VECTOR = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  peer;
        logic [3:0]  entry_index;
        logic [15:0] distance;
        logic [3:0]  hop;
        logic [15:0] link_cost;
        logic        last;
    } t_route_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic        deliver_local;
        logic [3:0]  forward_hop;
        logic [15:0] own_distance;
        logic [3:0]  own_hop;
        logic        table_changed;
        logic        vector_changed;
    } t_route_rsp;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic capture;
        logic rd;
        logic upd;
        logic fin;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
    } t_dp_sts;

endpackage

`default_nettype wire

[hdl/dvrt_req_if.sv]
// ============================================================================
// dvrt_req_if
// Request channel: valid/ready handshake carrying one table command.
// ============================================================================
`default_nettype none

interface dvrt_req_if
    import dvrt_pkg::*;
;
    logic       valid;
    logic       ready;
    t_route_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/dvrt_rsp_if.sv]
// ============================================================================
// dvrt_rsp_if
// Response channel: valid/ready handshake carrying one table result.
// ============================================================================
`default_nettype none

interface dvrt_rsp_if
    import dvrt_pkg::*;
;
    logic       valid;
    logic       ready;
    t_route_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/dvrt_ctrl.sv]
// ============================================================================
// dvrt_ctrl
// Sequencer: clearing pass, request capture, read, update, result load.
// ============================================================================
`default_nettype none

module dvrt_ctrl
    import dvrt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_fin;

    // load the result register only when it is free or being drained
    assign w_fin = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (w_fin) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_fin) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hdl/dvrt_dp.sv]
// ============================================================================
// dvrt_dp
// Route memory, relaxation arithmetic, change flags and result register.
// ============================================================================
`default_nettype none

module dvrt_dp
    import dvrt_pkg::*;
#(
    parameter int ROUTERS   = ROUTERS_DEF,
    parameter int DIST_BITS = DIST_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_sts         o_sts,
    input  wire t_route_req i_req,
    input  wire logic [3:0] i_self_id,
    output t_route_rsp      o_rsp
);

    localparam int IDX_W  = $clog2(ROUTERS);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int EXT_W  = ((DIST_BITS > 16) ? DIST_BITS : 16) + 1;
    localparam logic [6:0]           NUM_R = 7'(ROUTERS);
    localparam logic [DIST_BITS-1:0] DMAX  = '1;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic [3:0]           hop;
    } t_entry;

    localparam t_entry EMPTY = '{distance: DMAX, hop: 4'd0};

    t_entry           mem [DEPTH];
    t_entry           r_rd_own;
    t_entry           r_rd_peer;
    t_entry           r_own_new;
    logic             r_own_ok;
    logic             r_relax;
    t_route_req       r_req;
    t_route_rsp       r_rsp;
    logic             r_row_flag;
    logic             r_own_flag;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [3:0]        w_col;
    logic              w_self_ok;
    logic              w_peer_ok;
    logic              w_idx_ok;
    logic              w_col_ok;
    logic              w_is_self;
    logic [IDX_W-1:0]  w_self_i;
    logic [IDX_W-1:0]  w_peer_i;
    logic [IDX_W-1:0]  w_idx_i;
    logic [IDX_W-1:0]  w_col_i;
    logic [ADDR_W-1:0] w_own_addr;
    logic [ADDR_W-1:0] w_peer_addr;
    logic [EXT_W-1:0]  w_din_ext;
    logic [EXT_W-1:0]  w_sum;
    t_entry            w_in_entry;
    logic [DIST_BITS-1:0] w_sat;
    t_entry            w_own_eff;
    logic              w_vec_ok;
    logic              w_peer_diff;
    logic              w_relax;
    t_entry            w_own_next;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    t_entry            w_wr_data;
    t_entry            w_out_entry;
    logic [EXT_W-1:0]  w_out_dist;
    t_route_rsp        w_rsp;

    // ---------------- index decode ----------------
    assign w_col     = (r_req.cmd == CMD_LOOKUP) ? r_req.peer : r_req.entry_index;
    assign w_self_ok = 7'(i_self_id) < NUM_R;
    assign w_peer_ok = 7'(r_req.peer) < NUM_R;
    assign w_idx_ok  = 7'(r_req.entry_index) < NUM_R;
    assign w_col_ok  = 7'(w_col) < NUM_R;
    assign w_is_self = (r_req.peer == i_self_id);

    assign w_self_i = IDX_W'(8'(i_self_id));
    assign w_peer_i = IDX_W'(8'(r_req.peer));
    assign w_idx_i  = IDX_W'(8'(r_req.entry_index));
    assign w_col_i  = IDX_W'(8'(w_col));

    assign w_own_addr  = {w_self_i, w_col_i};
    assign w_peer_addr = {w_peer_i, w_idx_i};

    // ---------------- relaxation arithmetic ----------------
    assign w_din_ext           = EXT_W'(r_req.distance);
    assign w_in_entry.distance = (w_din_ext > EXT_W'(DMAX)) ? DMAX
                                                            : w_din_ext[DIST_BITS-1:0];
    assign w_in_entry.hop      = r_req.hop;
    assign w_sum = EXT_W'(w_in_entry.distance) + EXT_W'(r_req.link_cost);
    assign w_sat = (w_sum > EXT_W'(DMAX)) ? DMAX : w_sum[DIST_BITS-1:0];

    assign w_vec_ok    = (r_req.cmd == CMD_VECTOR) && w_peer_ok && w_idx_ok;
    assign w_peer_diff = (r_rd_peer != w_in_entry);
    // own row was just overwritten when the announcing peer is this router
    assign w_own_eff   = (w_vec_ok && w_is_self) ? w_in_entry : r_rd_own;
    assign w_relax     = w_vec_ok && w_self_ok && (w_sat < w_own_eff.distance);

    always_comb begin
        case (r_req.cmd)
            CMD_LOOKUP: w_own_next = r_rd_own;
            CMD_VECTOR: w_own_next = w_relax ? t_entry'{distance: w_sat, hop: r_req.peer}
                                             : w_own_eff;
            CMD_WRITE:  w_own_next = w_in_entry;
            default:    w_own_next = EMPTY;
        endcase
    end

    // ---------------- single write port ----------------
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_own_addr;
        w_wr_data = r_own_new;
        if (i_cmd.clr) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = EMPTY;
        end else if (i_cmd.upd && w_vec_ok && w_peer_diff) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_peer_addr;
            w_wr_data = w_in_entry;
        end else if (i_cmd.upd && (r_req.cmd == CMD_WRITE) && w_self_ok && w_idx_ok) begin
            w_wr_en   = 1'b1;
            w_wr_data = w_in_entry;
        end else if (i_cmd.fin && r_relax) begin
            w_wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_own  <= mem[w_own_addr];
            r_rd_peer <= mem[w_peer_addr];
        end
    end

    // ---------------- item and update registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.upd) begin
            r_own_new <= w_own_next;
            r_own_ok  <= w_self_ok && w_col_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_relax    <= 1'b0;
            r_row_flag <= 1'b0;
            r_own_flag <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.upd) begin
                r_relax <= w_relax;
                if (w_vec_ok && w_peer_diff) begin
                    r_row_flag <= 1'b1;
                end
                if (w_relax) begin
                    r_own_flag <= 1'b1;
                end
            end
            if (i_cmd.fin) begin
                r_relax <= 1'b0;
                if ((r_req.cmd == CMD_VECTOR) && r_req.last) begin
                    r_row_flag <= 1'b0;
                    r_own_flag <= 1'b0;
                end
            end
        end
    end

    // ---------------- result ----------------
    assign w_out_entry = r_own_ok ? r_own_new : EMPTY;
    assign w_out_dist  = EXT_W'(w_out_entry.distance);

    always_comb begin
        w_rsp      = '0;
        w_rsp.kind = r_req.cmd;
        if ((r_req.cmd == CMD_LOOKUP) || (r_req.cmd == CMD_VECTOR)
                || (r_req.cmd == CMD_WRITE)) begin
            w_rsp.own_distance = w_out_dist[15:0];
            w_rsp.own_hop      = w_out_entry.hop;
        end
        if (r_req.cmd == CMD_LOOKUP) begin
            w_rsp.deliver_local = w_is_self;
            w_rsp.forward_hop   = w_is_self ? 4'd0 : w_out_entry.hop;
        end
        if ((r_req.cmd == CMD_VECTOR) && r_req.last) begin
            w_rsp.table_changed  = r_row_flag;
            w_rsp.vector_changed = r_own_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp          = r_rsp;
    assign o_sts.clr_last = &r_clr_addr;

endmodule

`default_nettype wire

[hdl/distance_vector_route_table.sv]
// Sequence: a request is captured in idle and passes the read, update and done
//   states; its result loads once the output register is free or drained.
// Flow: a new request is taken only back in idle; each reads two route entries,
//   then makes up to two writes on the single memory write port.
// Reset: synchronous, active low; the route memory is then swept to distance
//   max / hop 0, one entry a cycle, (2**clog2(ROUTERS))**2 entries, ready low.
// ============================================================================
// distance_vector_route_table
// Distance-vector routing table with Bellman-Ford relaxation and APB setup.
// ============================================================================
`default_nettype none

module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int ROUTERS   = ROUTERS_DEF,
    parameter int DIST_BITS = DIST_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    dvrt_req_if.sink                   i_req,
    dvrt_rsp_if.source                 o_rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [3:0]  r_self_id;
    logic        w_reg_hit;
    logic        w_in_ready;
    logic        w_out_valid;
    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;
    t_route_rsp  w_rsp;

    // configuration register
    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[APB_ADDR_W-1:2] == REG_SELF_ID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id <= 4'd0;
        end else if (psel && penable && pwrite && w_reg_hit) begin
            r_self_id <= pwdata[3:0];
        end
    end

    assign prdata = w_reg_hit ? APB_DATA_W'(r_self_id) : '0;

    dvrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    dvrt_dp #(
        .ROUTERS   (ROUTERS),
        .DIST_BITS (DIST_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_req     (i_req.payload),
        .i_self_id (r_self_id),
        .o_rsp     (w_rsp)
    );

    assign i_req.ready   = w_in_ready;
    assign o_rsp.valid   = w_out_valid;
    assign o_rsp.payload = w_rsp;

endmodule

`default_nettype wire
